[sv/ceb_pkg.sv]
`default_nettype none
package ceb_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int RING_DEPTH_DEF   = 8;
    localparam int TIME_BITS_DEF    = 48;
    localparam int MAX_RESULTS      = 64;
    localparam int BUF_AW           = $clog2(MAX_RESULTS);
    localparam int RES_CW           = $clog2(MAX_RESULTS + 1);
    localparam int OUT_TIME_W       = 48;
    localparam int ENERGY_W         = 16;
    localparam int WINDOW_W         = 16;
    localparam int ACTIVE_W         = 4;
    localparam int HIT_CH_W         = 3;
    localparam int STATUS_W         = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int EVENT_W          = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd100;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_BUILD = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_EVENT   = 3'd0,
        ST_NODATA  = 3'd1,
        ST_PUSH_OK = 3'd2,
        ST_DROP    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_WINDOW = 2'd0,
        CFG_ACTIVE      = 2'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_CLEAR,
        S_SC_LAT,
        S_SC_RD,
        S_SC_CMP,
        S_SC_DONE,
        S_G_CHK,
        S_G_CMP,
        S_SEL_RD,
        S_SEL_CMP,
        S_EMIT_EV,
        S_EMIT_ONE
    } t_state;

    typedef struct packed {
        logic lt;
        logic gt;
        logic in_win;
        logic gt_win;
    } t_alu_res;

endpackage
`default_nettype wire

[sv/ceb_ram.sv]
`default_nettype none
module ceb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/ceb_time_alu.sv]
`default_nettype none
module ceb_time_alu
    import ceb_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [TIME_BITS-1:0] i_b,
    input  wire logic [WINDOW_W-1:0]  i_win,
    output t_alu_res                  o_res
);

    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] win_ext;

    assign diff    = i_a - i_b;
    assign win_ext = TIME_BITS'(i_win);

    always_comb begin
        o_res.lt     = i_a < i_b;
        o_res.gt     = i_a > i_b;
        o_res.in_win = !o_res.lt && ((diff < win_ext) || (diff == '0));
        o_res.gt_win = o_res.gt && (diff > win_ext);
    end

endmodule
`default_nettype wire

[sv/coincidence_event_builder.sv]
`default_nettype none
// Coincidence event builder. Hits are pushed into one ring per channel; a build
// request scans the active channel heads for the earliest hit, gathers every
// unread hit inside the time window, at most MAX_RESULTS of them, and returns
// the hits sorted by time, one transfer per hit, with last on the final one.
// All work runs through a single shared time compare/subtract unit and a hit
// memory with one registered read port. A push or an unknown request ends
// with a head scan for more_ready. A build runs two head scans, the gather
// walk, and a selection sort over the event buffer; a build that finds no
// data stops after the first head scan. Output stalls hold the emit states.
// The input side stalls until the last result of a request has been loaded
// into the output register.
module coincidence_event_builder
    import ceb_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [HIT_CH_W-1:0]   i_hit_channel,
    input  wire logic [OUT_TIME_W-1:0] i_hit_time,
    input  wire logic [ENERGY_W-1:0]   i_hit_energy,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [HIT_CH_W-1:0]        o_out_channel,
    output logic [OUT_TIME_W-1:0]      o_out_time,
    output logic [ENERGY_W-1:0]        o_out_energy,
    output logic [EVENT_W-1:0]         o_event_number,
    output logic                       o_last,
    output logic                       o_more_ready,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ACW  = $clog2(NUM_CHANNELS + 1);
    localparam int PW   = $clog2(RING_DEPTH);
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int HAW  = $clog2(NUM_CHANNELS * RING_DEPTH);
    localparam int HW   = TIME_BITS + ENERGY_W;
    localparam int BW   = CHW + TIME_BITS + ENERGY_W;

    t_state r_state, n_state;

    logic [WINDOW_W-1:0] r_window;
    logic [ACTIVE_W-1:0] r_active;
    logic [ACW-1:0]      act;

    t_req                 r_req;
    logic                 r_bad;
    logic [TIME_BITS-1:0] r_in_t;
    logic [ENERGY_W-1:0]  r_in_e;

    logic [PW-1:0]        r_wp     [NUM_CHANNELS];
    logic [PW-1:0]        r_rp     [NUM_CHANNELS];
    logic [CW-1:0]        r_cnt    [NUM_CHANNELS];
    logic [TIME_BITS-1:0] r_newest [NUM_CHANNELS];

    logic [CHW-1:0]       r_ci, n_ci;
    logic [ACW-1:0]       r_step, n_step;
    logic                 r_find, n_find;
    logic                 r_found, n_found;
    logic [TIME_BITS-1:0] r_et, n_et;
    logic [CHW-1:0]       r_ech, n_ech;
    logic [TIME_BITS-1:0] r_latest, n_latest;
    logic [EVENT_W-1:0]   r_events, n_events;
    logic                 r_more, n_more;
    t_status              r_stat, n_stat;

    logic [RES_CW-1:0]      r_n, n_n;
    logic [RES_CW-1:0]      r_k, n_k;
    logic [RES_CW-1:0]      r_j, n_j;
    logic [MAX_RESULTS-1:0] r_emitted, n_emitted;
    logic                   r_have, n_have;
    logic [BUF_AW-1:0]      r_minidx, n_minidx;
    logic [BW-1:0]          r_min, n_min;

    logic                 push_we;
    logic                 take;
    logic                 do_clear;
    logic                 slot_free;
    logic                 out_load;

    logic [HAW-1:0]       hit_raddr;
    logic [HAW-1:0]       hit_waddr;
    logic [HW-1:0]        hit_rdata;
    logic [TIME_BITS-1:0] hit_rt;
    logic [BW-1:0]        buf_rdata;
    logic [BW-1:0]        buf_wdata;
    logic [TIME_BITS-1:0] buf_rt;
    logic [TIME_BITS-1:0] min_t;

    logic [TIME_BITS-1:0] alu_a, alu_b;
    t_alu_res             alu;

    logic [CHW-1:0]       next_ci;
    logic [CW-1:0]        cur_cnt;

    logic                 n_oval;
    t_status              n_ostat;
    logic [BW-1:0]        n_odata;
    logic                 n_olast;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    always_comb begin
        if (32'(r_active) > NUM_CHANNELS) begin
            act = ACW'(NUM_CHANNELS);
        end else begin
            act = ACW'(r_active);
        end
    end

    assign cur_cnt   = r_cnt[r_ci];
    assign hit_raddr = HAW'(r_ci) * HAW'(RING_DEPTH) + HAW'(r_rp[r_ci]);
    assign hit_waddr = HAW'(r_ci) * HAW'(RING_DEPTH) + HAW'(r_wp[r_ci]);
    assign hit_rt    = hit_rdata[HW-1:ENERGY_W];
    assign buf_rt    = buf_rdata[TIME_BITS+ENERGY_W-1:ENERGY_W];
    assign min_t     = r_min[TIME_BITS+ENERGY_W-1:ENERGY_W];
    assign buf_wdata = {r_ci, hit_rdata};
    assign next_ci   = ((ACW'(r_ci) + ACW'(1)) == act) ? '0 : r_ci + CHW'(1);
    assign slot_free = !o_out_valid || !i_out_stall;

    ceb_ram #(.WIDTH(HW), .DEPTH(NUM_CHANNELS * RING_DEPTH)) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (hit_waddr),
        .i_wdata ({r_in_t, r_in_e}),
        .i_raddr (hit_raddr),
        .o_rdata (hit_rdata)
    );

    ceb_ram #(.WIDTH(BW), .DEPTH(MAX_RESULTS)) u_evt_buf (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (r_n[BUF_AW-1:0]),
        .i_wdata (buf_wdata),
        .i_raddr (r_j[BUF_AW-1:0]),
        .o_rdata (buf_rdata)
    );

    ceb_time_alu #(.TIME_BITS(TIME_BITS)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_win (r_window),
        .o_res (alu)
    );

    always_comb begin
        unique case (r_state)
            S_SC_LAT: begin
                alu_a = r_newest[r_ci];
                alu_b = r_latest;
            end
            S_SC_CMP, S_G_CMP: begin
                alu_a = hit_rt;
                alu_b = r_et;
            end
            S_SC_DONE: begin
                alu_a = r_latest;
                alu_b = r_et;
            end
            S_SEL_CMP: begin
                alu_a = buf_rt;
                alu_b = min_t;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority case (t_req'(i_req_type))
                        REQ_PUSH:  n_state = S_PUSH;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_SC_LAT;
                    endcase
                end
            end
            S_PUSH:   n_state = S_SC_LAT;
            S_CLEAR:  n_state = S_EMIT_ONE;
            S_SC_LAT: n_state = (r_step == act) ? S_SC_DONE : S_SC_RD;
            S_SC_RD:  n_state = (cur_cnt != '0) ? S_SC_CMP : S_SC_LAT;
            S_SC_CMP: n_state = S_SC_LAT;
            S_SC_DONE: begin
                if (r_req == REQ_BUILD && r_find) begin
                    n_state = r_found ? S_G_CHK : S_EMIT_ONE;
                end else if (r_req == REQ_BUILD) begin
                    n_state = S_SEL_RD;
                end else begin
                    n_state = S_EMIT_ONE;
                end
            end
            S_G_CHK: begin
                if (r_step == act) begin
                    n_state = S_SC_LAT;
                end else if (cur_cnt != '0 && r_n != RES_CW'(MAX_RESULTS)) begin
                    n_state = S_G_CMP;
                end
            end
            S_G_CMP: n_state = S_G_CHK;
            S_SEL_RD: begin
                if (r_j == r_n) begin
                    n_state = S_EMIT_EV;
                end else if (!r_emitted[r_j[BUF_AW-1:0]]) begin
                    n_state = S_SEL_CMP;
                end
            end
            S_SEL_CMP: n_state = S_SEL_RD;
            S_EMIT_EV: begin
                if (slot_free) begin
                    n_state = (r_k + RES_CW'(1) == r_n) ? S_IDLE : S_SEL_RD;
                end
            end
            S_EMIT_ONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_ci      = r_ci;
        n_step    = r_step;
        n_find    = r_find;
        n_found   = r_found;
        n_et      = r_et;
        n_ech     = r_ech;
        n_latest  = r_latest;
        n_events  = r_events;
        n_more    = r_more;
        n_stat    = r_stat;
        n_n       = r_n;
        n_k       = r_k;
        n_j       = r_j;
        n_emitted = r_emitted;
        n_have    = r_have;
        n_minidx  = r_minidx;
        n_min     = r_min;
        push_we   = 1'b0;
        take      = 1'b0;
        do_clear  = 1'b0;
        out_load  = 1'b0;
        n_ostat   = ST_EVENT;
        n_odata   = '0;
        n_olast   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                n_ci     = '0;
                n_step   = '0;
                n_found  = 1'b0;
                n_latest = '0;
                n_find   = (t_req'(i_req_type) == REQ_BUILD);
                n_stat   = ST_NODATA;
                if (i_in_valid && t_req'(i_req_type) == REQ_PUSH) begin
                    n_ci = CHW'(i_hit_channel);
                end
            end
            S_PUSH: begin
                if (r_bad || cur_cnt >= CW'(RING_DEPTH)) begin
                    n_stat = ST_DROP;
                end else begin
                    n_stat  = ST_PUSH_OK;
                    push_we = 1'b1;
                end
                n_ci = '0;
            end
            S_CLEAR: begin
                do_clear = 1'b1;
                n_events = '0;
                n_more   = 1'b0;
                n_stat   = ST_CLEARED;
            end
            S_SC_LAT: begin
                if (r_step != act && alu.gt) begin
                    n_latest = r_newest[r_ci];
                end
            end
            S_SC_RD: begin
                if (cur_cnt == '0) begin
                    n_step = r_step + ACW'(1);
                    n_ci   = r_ci + CHW'(1);
                end
            end
            S_SC_CMP: begin
                if (!r_found || alu.lt) begin
                    n_found = 1'b1;
                    n_et    = hit_rt;
                    n_ech   = r_ci;
                end
                n_step = r_step + ACW'(1);
                n_ci   = r_ci + CHW'(1);
            end
            S_SC_DONE: begin
                if (r_req == REQ_BUILD && r_find) begin
                    if (!r_found) begin
                        n_more = 1'b0;
                        n_stat = ST_NODATA;
                    end else begin
                        n_find    = 1'b0;
                        n_ci      = r_ech;
                        n_step    = '0;
                        n_n       = '0;
                        n_emitted = '0;
                    end
                end else begin
                    n_more = r_found && alu.gt_win;
                    n_k    = '0;
                    n_j    = '0;
                    n_have = 1'b0;
                end
            end
            S_G_CHK: begin
                if (r_step == act) begin
                    n_events = r_events + EVENT_W'(1);
                    n_ci     = '0;
                    n_step   = '0;
                    n_found  = 1'b0;
                    n_latest = '0;
                end else if (!(cur_cnt != '0 && r_n != RES_CW'(MAX_RESULTS))) begin
                    n_ci   = next_ci;
                    n_step = r_step + ACW'(1);
                end
            end
            S_G_CMP: begin
                if (alu.in_win) begin
                    take = 1'b1;
                    n_n  = r_n + RES_CW'(1);
                end else begin
                    n_ci   = next_ci;
                    n_step = r_step + ACW'(1);
                end
            end
            S_SEL_RD: begin
                if (r_j != r_n && r_emitted[r_j[BUF_AW-1:0]]) begin
                    n_j = r_j + RES_CW'(1);
                end
            end
            S_SEL_CMP: begin
                if (!r_have || alu.lt) begin
                    n_have   = 1'b1;
                    n_min    = buf_rdata;
                    n_minidx = r_j[BUF_AW-1:0];
                end
                n_j = r_j + RES_CW'(1);
            end
            S_EMIT_EV: begin
                if (slot_free) begin
                    out_load              = 1'b1;
                    n_ostat               = ST_EVENT;
                    n_odata               = r_min;
                    n_olast               = (r_k + RES_CW'(1) == r_n);
                    n_emitted[r_minidx]   = 1'b1;
                    n_k                   = r_k + RES_CW'(1);
                    n_j                   = '0;
                    n_have                = 1'b0;
                end
            end
            S_EMIT_ONE: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_ostat  = r_stat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= WINDOW_RST;
            r_active <= ACTIVE_RST;
            r_events <= '0;
        end else begin
            r_state  <= n_state;
            r_events <= n_events;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TIME_WINDOW) begin
                    r_window <= i_cfg_data[WINDOW_W-1:0];
                end else if (i_cfg_index == CFG_ACTIVE) begin
                    r_active <= i_cfg_data[ACTIVE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req  <= t_req'(i_req_type);
            r_bad  <= (32'(i_hit_channel) >= NUM_CHANNELS);
            r_in_t <= TIME_BITS'(i_hit_time);
            r_in_e <= i_hit_energy;
        end
        r_ci      <= n_ci;
        r_step    <= n_step;
        r_find    <= n_find;
        r_found   <= n_found;
        r_et      <= n_et;
        r_ech     <= n_ech;
        r_latest  <= n_latest;
        r_more    <= n_more;
        r_stat    <= n_stat;
        r_n       <= n_n;
        r_k       <= n_k;
        r_j       <= n_j;
        r_emitted <= n_emitted;
        r_have    <= n_have;
        r_minidx  <= n_minidx;
        r_min     <= n_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_clear) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_wp[c]     <= '0;
                r_rp[c]     <= '0;
                r_cnt[c]    <= '0;
                r_newest[c] <= '0;
            end
        end else if (push_we) begin
            r_wp[r_ci]     <= (r_wp[r_ci] == PW'(RING_DEPTH - 1)) ? '0 : r_wp[r_ci] + PW'(1);
            r_cnt[r_ci]    <= cur_cnt + CW'(1);
            r_newest[r_ci] <= r_in_t;
        end else if (take) begin
            r_rp[r_ci]  <= (r_rp[r_ci] == PW'(RING_DEPTH - 1)) ? '0 : r_rp[r_ci] + PW'(1);
            r_cnt[r_ci] <= cur_cnt - CW'(1);
        end
    end

    assign n_oval = out_load || (o_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_status       <= n_ostat;
            o_out_channel  <= HIT_CH_W'(n_odata[BW-1:TIME_BITS+ENERGY_W]);
            o_out_time     <= OUT_TIME_W'(n_odata[TIME_BITS+ENERGY_W-1:ENERGY_W]);
            o_out_energy   <= n_odata[ENERGY_W-1:0];
            o_event_number <= n_events;
            o_last         <= n_olast;
            o_more_ready   <= (r_state == S_EMIT_EV) ? r_more : n_more;
        end
    end

`ifndef NO_ASSERTIONS
    a_k_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_EV) |-> (r_k < r_n))
        else $error("emit count passed gathered count");

    a_min_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_EV) |-> r_have)
        else $error("emit without a selected hit");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_CHK) |-> (cur_cnt <= CW'(RING_DEPTH)))
        else $error("ring count above depth");

    a_gather_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (r_n < RES_CW'(MAX_RESULTS)))
        else $error("gather beyond event buffer");
`endif

endmodule
`default_nettype wire
